/* src/itp_pkg.sv */
// shared types, constants and helpers for the isometric tile picker
`timescale 1ns / 1ps

package itp_pkg;

  // mouse map geometry
  localparam int MAP_WIDTH_MAX  = 64;
  localparam int MAP_HEIGHT_MAX = 64;
  localparam int MAP_DEPTH      = MAP_WIDTH_MAX * MAP_HEIGHT_MAX;
  localparam int MAP_AW         = $clog2(MAP_DEPTH);

  // field widths
  localparam int MOUSE_W   = 12;
  localparam int MAP_IDX_W = 6;
  localparam int CODE_W    = 3;
  localparam int TILE_X_W  = 13;
  localparam int TILE_Y_W  = 14;
  localparam int PIXEL_W   = 19;

  // divider
  localparam int DIVIDEND_W     = MOUSE_W;
  localparam int DIVISOR_W      = 7;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = DIVIDEND_W / BITS_PER_STAGE;

  // configuration
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int HALF_W  = 6;

  localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HALF_HEIGHT = 2'd3;

  localparam logic [DIVISOR_W-1:0] TILE_WIDTH_RST  = 7'd64;
  localparam logic [DIVISOR_W-1:0] TILE_HEIGHT_RST = 7'd32;
  localparam logic [HALF_W-1:0]    HALF_WIDTH_RST  = 6'd32;
  localparam logic [HALF_W-1:0]    HALF_HEIGHT_RST = 6'd16;

  // item kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PICK = 1'b1;

  // region codes
  localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_UP_LEFT   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_UP        = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DOWN_LEFT = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DOWN      = 3'd4;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] num;
    logic [DIVIDEND_W-1:0] quo;
    logic [DIVISOR_W-1:0]  rem;
  } div_stage_t;

  // item fields that ride beside the dividers
  typedef struct packed {
    logic                 pick;
    logic [MAP_IDX_W-1:0] row;
    logic [MAP_IDX_W-1:0] col;
    logic [CODE_W-1:0]    code;
  } side_t;

  typedef struct packed {
    logic                  valid;
    side_t                 side;
    logic [DIVIDEND_W-1:0] qx;
    logic [DIVIDEND_W-1:0] qy;
    logic [DIVISOR_W-1:0]  ox;
    logic [DIVISOR_W-1:0]  oy;
  } map_req_t;

  typedef struct packed {
    logic                  valid;
    logic                  pick;
    logic [DIVIDEND_W-1:0] qx;
    logic [DIVIDEND_W-1:0] qy;
    logic [CODE_W-1:0]     code;
  } map_rsp_t;

  typedef struct packed {
    logic signed [PIXEL_W-1:0]  pixel_y;
    logic signed [PIXEL_W-1:0]  pixel_x;
    logic signed [TILE_Y_W-1:0] tile_y;
    logic signed [TILE_X_W-1:0] tile_x;
  } result_t;

  // zero reads as one, oversized reads as the map limit
  function automatic logic [DIVISOR_W-1:0] clamp_div(input logic [DIVISOR_W-1:0] v,
                                                     input int lim);
    logic [DIVISOR_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIVISOR_W'(1);
    end else if (32'(v) > lim) begin
      r = DIVISOR_W'(lim);
    end
    return r;
  endfunction

endpackage

/* src/itp_divider.sv */
// pipelined restoring divider, a fixed number of quotient bits per stage
`timescale 1ns / 1ps

module itp_divider (
  input  logic                             clk,
  input  logic                             en,
  input  logic [itp_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [itp_pkg::DIVISOR_W-1:0]    divisor,
  output logic [itp_pkg::DIVIDEND_W-1:0]   quotient,
  output logic [itp_pkg::DIVISOR_W-1:0]    remainder
);

  function automatic itp_pkg::div_stage_t div_step(input itp_pkg::div_stage_t s,
                                                   input logic [itp_pkg::DIVISOR_W-1:0] d);
    itp_pkg::div_stage_t r;
    logic [itp_pkg::DIVISOR_W:0] t;
    r = s;
    for (int k = 0; k < itp_pkg::BITS_PER_STAGE; k++) begin
      t = {r.rem, r.num[itp_pkg::DIVIDEND_W-1]};
      r.num = {r.num[itp_pkg::DIVIDEND_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = itp_pkg::DIVISOR_W'(t - {1'b0, d});
        r.quo = {r.quo[itp_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        r.rem = t[itp_pkg::DIVISOR_W-1:0];
        r.quo = {r.quo[itp_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  itp_pkg::div_stage_t seed;
  itp_pkg::div_stage_t stg [itp_pkg::DIV_STAGES];

  assign seed = '{num: dividend, quo: '0, rem: '0};

  for (genvar i = 0; i < itp_pkg::DIV_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          stg[0] <= div_step(seed, divisor);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          stg[i] <= div_step(stg[i-1], divisor);
        end
      end
    end
  end

  assign quotient  = stg[itp_pkg::DIV_STAGES-1].quo;
  assign remainder = stg[itp_pkg::DIV_STAGES-1].rem;

endmodule

/* src/itp_map.sv */
// mouse map store: loads write and picks read at the same stage, in item order
`timescale 1ns / 1ps

module itp_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  itp_pkg::map_req_t   req,
  output itp_pkg::map_rsp_t   rsp
);

  logic [itp_pkg::CODE_W-1:0] mem [itp_pkg::MAP_DEPTH];
  logic [itp_pkg::MAP_AW-1:0] waddr;
  logic [itp_pkg::MAP_AW-1:0] raddr;
  logic                       in_map;
  logic                       wr;
  logic                       valid;
  logic                       pick;
  logic [itp_pkg::DIVIDEND_W-1:0] qx;
  logic [itp_pkg::DIVIDEND_W-1:0] qy;
  logic [itp_pkg::CODE_W-1:0] code;

  assign in_map = (32'(req.side.row) < itp_pkg::MAP_HEIGHT_MAX) &&
                  (32'(req.side.col) < itp_pkg::MAP_WIDTH_MAX);
  assign waddr  = itp_pkg::MAP_AW'(32'(req.side.row) * itp_pkg::MAP_WIDTH_MAX
                                   + 32'(req.side.col));
  assign raddr  = itp_pkg::MAP_AW'(32'(req.oy) * itp_pkg::MAP_WIDTH_MAX + 32'(req.ox));
  assign wr     = req.valid && (req.side.pick == itp_pkg::ACT_LOAD) && in_map;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        mem[waddr] <= req.side.code;
      end
      code <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick <= req.side.pick;
      qx   <= req.qx;
      qy   <= req.qy;
    end
  end

  assign rsp = '{valid: valid, pick: pick, qx: qx, qy: qy, code: code};

endmodule

/* src/itp_place.sv */
// tile nudge by region code, then pixel position and the output register
`timescale 1ns / 1ps

module itp_place (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  itp_pkg::map_rsp_t                rsp,
  input  logic [itp_pkg::DIVISOR_W-1:0]    w_eff,
  input  logic [itp_pkg::HALF_W-1:0]       half_width,
  input  logic [itp_pkg::HALF_W-1:0]       half_height,
  output logic                             out_valid,
  output itp_pkg::result_t                 out_data
);

  localparam int PROD_W = itp_pkg::PIXEL_W + 2;

  logic                                 j_valid;
  logic                                 j_pick;
  logic signed [itp_pkg::TILE_X_W-1:0]  j_tx;
  logic signed [itp_pkg::TILE_Y_W-1:0]  j_ty;
  logic signed [itp_pkg::TILE_X_W-1:0]  tx_next;
  logic signed [itp_pkg::TILE_Y_W-1:0]  ty_next;
  logic signed [itp_pkg::TILE_X_W-1:0]  tx_base;
  logic signed [itp_pkg::TILE_Y_W-1:0]  ty_base;
  logic signed [PROD_W-1:0]             px_full;
  logic signed [PROD_W-1:0]             px_sum;
  logic signed [PROD_W-1:0]             py_full;

  // coarse region: column as is, row doubled
  assign tx_base = $signed({1'b0, rsp.qx});
  assign ty_base = $signed({1'b0, rsp.qy, 1'b0});

  always_comb begin
    tx_next = tx_base;
    ty_next = ty_base;
    case (rsp.code)
      itp_pkg::CODE_UP_LEFT: begin
        tx_next = tx_base - 13'sd1;
        ty_next = ty_base - 14'sd1;
      end
      itp_pkg::CODE_UP: begin
        ty_next = ty_base - 14'sd1;
      end
      itp_pkg::CODE_DOWN_LEFT: begin
        tx_next = tx_base - 13'sd1;
        ty_next = ty_base + 14'sd1;
      end
      itp_pkg::CODE_DOWN: begin
        ty_next = ty_base + 14'sd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (en) begin
      j_valid <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_pick <= rsp.pick;
      j_tx   <= tx_next;
      j_ty   <= ty_next;
    end
  end

  assign px_full = j_tx * $signed({1'b0, w_eff});
  // odd rows, row -1 included, sit half a width to the right
  assign px_sum  = j_ty[0] ? px_full + $signed(PROD_W'(half_width)) : px_full;
  assign py_full = j_ty * $signed({1'b0, half_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= j_valid && (j_pick == itp_pkg::ACT_PICK);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.tile_x  <= j_tx;
      out_data.tile_y  <= j_ty;
      out_data.pixel_x <= px_sum[itp_pkg::PIXEL_W-1:0];
      out_data.pixel_y <= py_full[itp_pkg::PIXEL_W-1:0];
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(j_valid) && $stable(out_valid))
    else $error("pipeline moved while stalled");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    en && j_valid && (j_pick == itp_pkg::ACT_LOAD) |=> !out_valid)
    else $error("load item produced a result");

  a_pick_result: assert property (@(posedge clk) disable iff (rst)
    en && j_valid && (j_pick == itp_pkg::ACT_PICK) |=> out_valid)
    else $error("pick item lost its result");

endmodule

/* src/isometric_tile_picker_unit.sv */
// isometric tile picker top level: stream ports, register file, pipeline
`timescale 1ns / 1ps

// Maps a pointer position to a tile of a staggered isometric grid using a
// 64 x 64 mouse map of region codes. Load items (tuser 0) write one map code,
// pick items (tuser 1) return one result each; loads return nothing. One item
// is taken per clock while the output is not stalled; the pipeline is nine
// stages deep (six divider stages at two quotient bits each, the map store
// read, the region nudge and the multiply and output register). The whole
// pipeline holds while a result waits on m_tready. Loads write the map at the
// same stage where picks read it, so items see the map in the order they were
// given. Map entries have no reset value: pick only offsets that were loaded.
// Registers are to be written by the user only while no item is in flight;
// the block itself does not enforce it.

module isometric_tile_picker_unit (
  input  logic                        clk,
  input  logic                        rst,
  // mouse_x[11:0], mouse_y[23:12], map_row[29:24], map_col[35:30],
  // map_code[38:36], zero pad [39]
  input  logic [39:0]                 s_tdata,
  // action: 0 load, 1 pick
  input  logic                        s_tuser,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tile_x[12:0], tile_y[26:13], pixel_x[45:27], pixel_y[64:46], zero pad [71:65]
  output logic [71:0]                 m_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [itp_pkg::CFG_AW-1:0]  paddr,
  input  logic [itp_pkg::CFG_DW-1:0]  pwdata,
  output logic [itp_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  logic [itp_pkg::DIVISOR_W-1:0] tile_width;
  logic [itp_pkg::DIVISOR_W-1:0] tile_height;
  logic [itp_pkg::HALF_W-1:0]    half_width;
  logic [itp_pkg::HALF_W-1:0]    half_height;
  logic [itp_pkg::DIVISOR_W-1:0] w_eff;
  logic [itp_pkg::DIVISOR_W-1:0] h_eff;
  logic                          cfg_wr;

  logic                          advance;
  logic                          accept;
  itp_pkg::side_t                side_in;
  itp_pkg::side_t                side_q [itp_pkg::DIV_STAGES];
  logic                          vld_q  [itp_pkg::DIV_STAGES];

  logic [itp_pkg::DIVIDEND_W-1:0] qx;
  logic [itp_pkg::DIVIDEND_W-1:0] qy;
  logic [itp_pkg::DIVISOR_W-1:0]  ox;
  logic [itp_pkg::DIVISOR_W-1:0]  oy;

  itp_pkg::map_req_t             map_req;
  itp_pkg::map_rsp_t             map_rsp;
  itp_pkg::result_t              result;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= itp_pkg::TILE_WIDTH_RST;
      tile_height <= itp_pkg::TILE_HEIGHT_RST;
      half_width  <= itp_pkg::HALF_WIDTH_RST;
      half_height <= itp_pkg::HALF_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        itp_pkg::REG_TILE_WIDTH:  tile_width  <= pwdata[itp_pkg::DIVISOR_W-1:0];
        itp_pkg::REG_TILE_HEIGHT: tile_height <= pwdata[itp_pkg::DIVISOR_W-1:0];
        itp_pkg::REG_HALF_WIDTH:  half_width  <= pwdata[itp_pkg::HALF_W-1:0];
        itp_pkg::REG_HALF_HEIGHT: half_height <= pwdata[itp_pkg::HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      itp_pkg::REG_TILE_WIDTH:  prdata = itp_pkg::CFG_DW'(tile_width);
      itp_pkg::REG_TILE_HEIGHT: prdata = itp_pkg::CFG_DW'(tile_height);
      itp_pkg::REG_HALF_WIDTH:  prdata = itp_pkg::CFG_DW'(half_width);
      itp_pkg::REG_HALF_HEIGHT: prdata = itp_pkg::CFG_DW'(half_height);
      default:                  prdata = '0;
    endcase
  end

  assign w_eff = itp_pkg::clamp_div(tile_width, itp_pkg::MAP_WIDTH_MAX);
  assign h_eff = itp_pkg::clamp_div(tile_height, itp_pkg::MAP_HEIGHT_MAX);

  // global stall: everything moves when the output slot is free or taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  assign side_in = '{pick: s_tuser, row: s_tdata[29:24], col: s_tdata[35:30],
                     code: s_tdata[38:36]};

  itp_divider u_div_x (
    .clk       (clk),
    .en        (advance),
    .dividend  (s_tdata[11:0]),
    .divisor   (w_eff),
    .quotient  (qx),
    .remainder (ox)
  );

  itp_divider u_div_y (
    .clk       (clk),
    .en        (advance),
    .dividend  (s_tdata[23:12]),
    .divisor   (h_eff),
    .quotient  (qy),
    .remainder (oy)
  );

  // item fields and valid bits ride beside the divider stages
  for (genvar i = 0; i < itp_pkg::DIV_STAGES; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[0] <= 1'b0;
        end else if (advance) begin
          vld_q[0] <= accept;
        end
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          side_q[0] <= side_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[i] <= 1'b0;
        end else if (advance) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign map_req = '{valid: vld_q[itp_pkg::DIV_STAGES-1],
                     side:  side_q[itp_pkg::DIV_STAGES-1],
                     qx: qx, qy: qy, ox: ox, oy: oy};

  itp_map u_map (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (map_req),
    .rsp (map_rsp)
  );

  itp_place u_place (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .rsp         (map_rsp),
    .w_eff       (w_eff),
    .half_width  (half_width),
    .half_height (half_height),
    .out_valid   (m_tvalid),
    .out_data    (result)
  );

  assign m_tdata = {7'b0, result.pixel_y, result.pixel_x, result.tile_y, result.tile_x};

endmodule
